FILE: rtl/wav_stream_parser_macros.svh
// assertion macros shared by the wav stream parser rtl
`ifndef WAV_STREAM_PARSER_MACROS_SVH
`define WAV_STREAM_PARSER_MACROS_SVH

// same-cycle implication under reset
`define WSP_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under reset
`define WSP_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/wsp_pkg.sv
// shared types and constants of the wav stream parser
package wsp_pkg;

	// chunk tags as little-endian words
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// register indexes
	localparam logic [1:0] REG_RATE       = 2'd0;
	localparam logic [1:0] REG_MAX_FRAMES = 2'd1;
	localparam logic [1:0] REG_MAX_BYTES  = 2'd2;

	localparam logic [31:0] RATE_RESET       = 32'd48000;
	localparam logic [31:0] MAX_FRAMES_RESET = 32'd28800000;
	localparam logic [31:0] MAX_BYTES_RESET  = 32'd536870912;

	// status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_TOO_BIG     = 4'd1;
	localparam logic [3:0] ST_NOT_WAVE    = 4'd2;
	localparam logic [3:0] ST_OVERRUN     = 4'd3;
	localparam logic [3:0] ST_SMALL_FMT   = 4'd4;
	localparam logic [3:0] ST_NO_FMT      = 4'd5;
	localparam logic [3:0] ST_NO_DATA     = 4'd6;
	localparam logic [3:0] ST_RATE        = 4'd7;
	localparam logic [3:0] ST_CHANNELS    = 4'd8;
	localparam logic [3:0] ST_FORMAT      = 4'd9;
	localparam logic [3:0] ST_ALIGN       = 4'd10;
	localparam logic [3:0] ST_PARTIAL     = 4'd11;
	localparam logic [3:0] ST_NO_FRAMES   = 4'd12;
	localparam logic [3:0] ST_MANY_FRAMES = 4'd13;
	localparam logic [3:0] ST_DATA_EARLY  = 4'd14;

	localparam logic [15:0] FMT_PCM   = 16'd1;
	localparam logic [15:0] FMT_FLOAT = 16'd3;

	// controller to datapath commands
	typedef struct packed {
		logic clear;
		logic shift_id;
		logic shift_size;
		logic pos_inc;
		logic pos_clr;
		logic pad_load;
		logic pad_clr;
		logic fmt_cap;
		logic data_byte;
		logic frame_clr;
		logic cbl_dec;
		logic fmt_seen;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic       too_big;
		logic [4:0] pos;
		logic       hdr_bad;
		logic       size_zero;
		logic       size_lt16;
		logic       cid_fmt;
		logic       cid_data;
		logic [3:0] data_err;
		logic       body_end;
		logic       pad;
		logic       cbl_nxt_nz;
	} stat_t;

	// one result word
	typedef struct packed {
		logic        kind;
		logic [31:0] left;
		logic [31:0] right;
		logic [3:0]  code;
		logic        last;
	} res_t;

endpackage

FILE: rtl/wsp_datapath.sv
// datapath: config registers, counters, captured fmt fields, frame assembly
module wsp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               acc,
	input  logic [7:0]         in_byte,
	input  wsp_pkg::cmd_t      cmd,
	output wsp_pkg::stat_t     stat,
	output logic               sample_valid,
	output logic [31:0]        left,
	output logic [31:0]        right
);

	logic [31:0] rate_cfg_q, max_frames_q, max_bytes_q;
	logic [31:0] fbc_q, cid_q, cbl_q, fmt_rate_q;
	logic [4:0]  pos_q;
	logic        pad_q;
	logic [15:0] fc_q, ch_q, bb_q, sb_q;
	logic [63:0] fbuf_q;
	logic [2:0]  fbi_q;

	logic [31:0] cid_n, size_n, cbl_dec_v, cbl_nxt;
	logic [63:0] fbuf_n;
	logic        frame_done;
	logic [31:0] frames;
	logic [15:0] expect_bb;
	logic [3:0]  derr;

	// int16 over 32768 as float32
	function automatic logic [31:0] pcm_to_f32(input logic [15:0] v);
		logic        sgn;
		logic [15:0] mag;
		logic [3:0]  p;
		logic [23:0] norm;
		sgn = v[15];
		mag = sgn ? (~v + 16'd1) : v;
		p = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (mag[i]) p = 4'(i);
		end
		norm = {8'd0, mag} << (5'd23 - {1'b0, p});
		return (mag == 16'd0) ? 32'd0 : {sgn, {4'd0, p} + 8'd112, norm[22:0]};
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_cfg_q   <= wsp_pkg::RATE_RESET;
			max_frames_q <= wsp_pkg::MAX_FRAMES_RESET;
			max_bytes_q  <= wsp_pkg::MAX_BYTES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wsp_pkg::REG_RATE:       rate_cfg_q   <= cfg_data;
				wsp_pkg::REG_MAX_FRAMES: max_frames_q <= cfg_data;
				wsp_pkg::REG_MAX_BYTES:  max_bytes_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// shifted words
	assign cid_n     = {in_byte, cid_q[31:8]};
	assign size_n    = {in_byte, cbl_q[31:8]};
	assign cbl_dec_v = (cbl_q != 32'd0) ? cbl_q - 32'd1 : 32'd0;

	// data chunk checks, align is 2, 4 or 8 once earlier checks pass
	always_comb begin
		expect_bb = 16'd0;
		frames    = size_n;
		case ({ch_q[1:0], sb_q[5]})
			3'b010:  expect_bb = 16'd2;
			3'b011:  expect_bb = 16'd4;
			3'b100:  expect_bb = 16'd4;
			3'b101:  expect_bb = 16'd8;
			default: expect_bb = 16'd0;
		endcase
		if (bb_q == 16'd2) frames = {1'b0, size_n[31:1]};
		else if (bb_q == 16'd4) frames = {2'b0, size_n[31:2]};
		else frames = {3'b0, size_n[31:3]};
		if (!cmd.fmt_seen) derr = wsp_pkg::ST_DATA_EARLY;
		else if (fmt_rate_q != rate_cfg_q) derr = wsp_pkg::ST_RATE;
		else if (ch_q != 16'd1 && ch_q != 16'd2) derr = wsp_pkg::ST_CHANNELS;
		else if (!((fc_q == wsp_pkg::FMT_PCM && sb_q == 16'd16) ||
			(fc_q == wsp_pkg::FMT_FLOAT && sb_q == 16'd32))) derr = wsp_pkg::ST_FORMAT;
		else if (bb_q != expect_bb) derr = wsp_pkg::ST_ALIGN;
		else if ((size_n[2:0] & (bb_q[2:0] - 3'd1)) != 3'd0) derr = wsp_pkg::ST_PARTIAL;
		else if (frames == 32'd0) derr = wsp_pkg::ST_NO_FRAMES;
		else if (frames > max_frames_q) derr = wsp_pkg::ST_MANY_FRAMES;
		else derr = wsp_pkg::ST_OK;
	end

	// chunk length after this byte
	always_comb begin
		cbl_nxt = cbl_q;
		if (cmd.shift_size) cbl_nxt = size_n;
		if (cmd.cbl_dec) cbl_nxt = cbl_dec_v;
	end

	// frame assembly and sample conversion
	always_comb begin
		fbuf_n = fbuf_q;
		fbuf_n[{fbi_q, 3'b000} +: 8] = fbuf_q[{fbi_q, 3'b000} +: 8] | in_byte;
		frame_done = ({13'd0, fbi_q} + 16'd1 >= bb_q) || (fbi_q == 3'd7);
		if (fc_q == wsp_pkg::FMT_PCM) begin
			left  = pcm_to_f32(fbuf_n[15:0]);
			right = (ch_q == 16'd2) ? pcm_to_f32(fbuf_n[31:16]) : left;
		end else begin
			left  = fbuf_n[31:0];
			right = (ch_q == 16'd2) ? fbuf_n[63:32] : left;
		end
	end
	assign sample_valid = cmd.data_byte && frame_done;

	assign stat.too_big    = fbc_q >= max_bytes_q;
	assign stat.pos        = pos_q;
	assign stat.hdr_bad    = (pos_q == 5'd3 && cid_n != wsp_pkg::TAG_RIFF) ||
		(pos_q == 5'd11 && cid_n != wsp_pkg::TAG_WAVE);
	assign stat.size_zero  = size_n == 32'd0;
	assign stat.size_lt16  = size_n < 32'd16;
	assign stat.cid_fmt    = cid_q == wsp_pkg::TAG_FMT;
	assign stat.cid_data   = cid_q == wsp_pkg::TAG_DATA;
	assign stat.data_err   = derr;
	assign stat.body_end   = cbl_dec_v == 32'd0;
	assign stat.pad        = pad_q;
	assign stat.cbl_nxt_nz = cbl_nxt != 32'd0;

	// parse registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbc_q <= '0; cid_q <= '0; cbl_q <= '0; fmt_rate_q <= '0; pos_q <= '0;
			pad_q <= 1'b0; fc_q <= '0; ch_q <= '0; bb_q <= '0; sb_q <= '0;
			fbuf_q <= '0; fbi_q <= '0;
		end else if (acc) begin
			if (cmd.clear) begin
				fbc_q <= '0; cid_q <= '0; cbl_q <= '0; fmt_rate_q <= '0; pos_q <= '0;
				pad_q <= 1'b0; fc_q <= '0; ch_q <= '0; bb_q <= '0; sb_q <= '0;
				fbuf_q <= '0; fbi_q <= '0;
			end else begin
				if (fbc_q != 32'hFFFF_FFFF) fbc_q <= fbc_q + 32'd1;
				if (cmd.shift_id) cid_q <= cid_n;
				cbl_q <= cbl_nxt;
				if (cmd.pos_clr) pos_q <= '0;
				else if (cmd.pos_inc) pos_q <= pos_q + 5'd1;
				if (cmd.pad_load) pad_q <= size_n[0];
				else if (cmd.pad_clr) pad_q <= 1'b0;
				// fmt field capture by body position
				if (cmd.fmt_cap) begin
					case (pos_q)
						5'd0:  fc_q <= {8'd0, in_byte};
						5'd1:  fc_q[15:8] <= fc_q[15:8] | in_byte;
						5'd2:  ch_q <= {8'd0, in_byte};
						5'd3:  ch_q[15:8] <= ch_q[15:8] | in_byte;
						5'd4, 5'd5, 5'd6, 5'd7: fmt_rate_q <= {in_byte, fmt_rate_q[31:8]};
						5'd12: bb_q <= {8'd0, in_byte};
						5'd13: bb_q[15:8] <= bb_q[15:8] | in_byte;
						5'd14: sb_q <= {8'd0, in_byte};
						5'd15: sb_q[15:8] <= sb_q[15:8] | in_byte;
						default: ;
					endcase
				end
				if (cmd.frame_clr) begin
					fbuf_q <= '0;
					fbi_q  <= '0;
				end else if (cmd.data_byte) begin
					if (frame_done) begin
						fbuf_q <= '0;
						fbi_q  <= '0;
					end else begin
						fbuf_q <= fbuf_n;
						fbi_q  <= fbi_q + 3'd1;
					end
				end
			end
		end
	end

endmodule

FILE: rtl/wsp_ctrl.sv
// controller: parse phase, latched error, seen flags and end status
module wsp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  logic           eof,
	input  wsp_pkg::stat_t stat,
	output wsp_pkg::cmd_t  cmd,
	output logic           status_valid,
	output logic [3:0]     status_code
);

	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_CHUNK_HDR = 3'd1;
	localparam logic [2:0] PH_FMT      = 3'd2;
	localparam logic [2:0] PH_DATA     = 3'd3;
	localparam logic [2:0] PH_SKIP     = 3'd4;
	localparam logic [2:0] PH_PAD      = 3'd5;

	logic [2:0] ph_q, ph_n, ph_p;
	logic [3:0] err_q, err_n;
	logic [1:0] seen_q, seen_n;
	logic       run;

	assign run = acc && !stat.too_big && err_q == wsp_pkg::ST_OK;

	// next phase and commands for one byte
	always_comb begin
		cmd = '0;
		cmd.fmt_seen = seen_q[0];
		// clear the datapath along with the controller at end of file
		cmd.clear = acc && eof;
		ph_p  = ph_q;
		err_n = stat.too_big ? wsp_pkg::ST_TOO_BIG : err_q;
		seen_n = seen_q;
		if (run) begin
			case (ph_q)
				PH_HEADER: begin
					cmd.shift_id = 1'b1;
					if (stat.hdr_bad) begin
						err_n = wsp_pkg::ST_NOT_WAVE;
					end else begin
						cmd.pos_inc = 1'b1;
						if (stat.pos >= 5'd11) begin
							ph_p = PH_CHUNK_HDR;
							cmd.pos_clr = 1'b1;
						end
					end
				end
				PH_CHUNK_HDR: begin
					cmd.shift_id   = stat.pos < 5'd4;
					cmd.shift_size = stat.pos >= 5'd4;
					cmd.pos_inc    = 1'b1;
					if (stat.pos >= 5'd7) begin
						cmd.pos_clr  = 1'b1;
						cmd.pad_load = 1'b1;
						if (eof && !stat.size_zero) begin
							ph_p = PH_SKIP;
						end else if (stat.cid_fmt) begin
							if (stat.size_lt16) begin
								err_n = wsp_pkg::ST_SMALL_FMT;
							end else begin
								seen_n[0] = 1'b1;
								ph_p = PH_FMT;
							end
						end else if (stat.cid_data && !seen_q[1]) begin
							if (stat.data_err != wsp_pkg::ST_OK) begin
								err_n = stat.data_err;
							end else begin
								seen_n[1] = 1'b1;
								cmd.frame_clr = 1'b1;
								ph_p = PH_DATA;
							end
						end else begin
							ph_p = stat.size_zero ? PH_CHUNK_HDR : PH_SKIP;
						end
					end
				end
				PH_FMT, PH_DATA, PH_SKIP: begin
					cmd.fmt_cap   = ph_q == PH_FMT;
					cmd.pos_inc   = (ph_q == PH_FMT) && (stat.pos < 5'd16);
					cmd.data_byte = ph_q == PH_DATA;
					cmd.cbl_dec   = 1'b1;
					if (stat.body_end) begin
						ph_p = stat.pad ? PH_PAD : PH_CHUNK_HDR;
						cmd.pos_clr = 1'b1;
					end
				end
				PH_PAD: begin
					cmd.pad_clr = 1'b1;
					cmd.pos_clr = 1'b1;
					ph_p = PH_CHUNK_HDR;
				end
				default: begin
					cmd.pos_clr = 1'b1;
					ph_p = PH_CHUNK_HDR;
				end
			endcase
		end
	end

	// end of file status, then start over
	always_comb begin
		status_valid = acc && eof;
		if (err_n != wsp_pkg::ST_OK) status_code = err_n;
		else if (ph_p == PH_HEADER) status_code = wsp_pkg::ST_NOT_WAVE;
		else if ((ph_p inside {PH_FMT, PH_DATA, PH_SKIP}) && stat.cbl_nxt_nz)
			status_code = wsp_pkg::ST_OVERRUN;
		else if (!seen_n[0]) status_code = wsp_pkg::ST_NO_FMT;
		else if (!seen_n[1]) status_code = wsp_pkg::ST_NO_DATA;
		else status_code = wsp_pkg::ST_OK;
		ph_n = status_valid ? PH_HEADER : ph_p;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_HEADER;
			err_q  <= wsp_pkg::ST_OK;
			seen_q <= 2'b00;
		end else if (acc) begin
			ph_q   <= ph_n;
			err_q  <= eof ? wsp_pkg::ST_OK : err_n;
			seen_q <= eof ? 2'b00 : seen_n;
		end
	end

endmodule

FILE: rtl/wsp_outq.sv
// two-word result buffer between the parser and the output stream
module wsp_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic          sample_valid,
	input  logic [31:0]   left,
	input  logic [31:0]   right,
	input  logic          status_valid,
	input  logic [3:0]    status_code,
	output logic          ready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output wsp_pkg::res_t head,
	output logic [1:0]    count
);

	wsp_pkg::res_t q0_q, q1_q, r0, r1;
	logic [1:0]    cnt_q;
	logic          pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != 2'd0;
	assign ready    = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign head     = q0_q;
	assign count    = cnt_q;

	// sample word first, status word last
	always_comb begin
		r1 = '{kind: 1'b1, left: 32'd0, right: 32'd0, code: status_code, last: 1'b1};
		if (sample_valid)
			r0 = '{kind: 1'b0, left: left, right: right, code: wsp_pkg::ST_OK,
				last: !status_valid};
		else
			r0 = r1;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q0_q <= r0;
			q1_q <= r1;
		end else if (pop) begin
			q0_q <= q1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= 2'd0;
		else if (push) cnt_q <= {1'b0, sample_valid} + {1'b0, status_valid};
		else if (pop) cnt_q <= cnt_q - 2'd1;
	end

endmodule

FILE: rtl/wav_stream_parser.sv
// top level of the wav stream parser
// Takes a RIFF/WAVE file one byte per word on the s_ side; s_tlast marks the
// last byte of a file. Stereo float32 sample pairs leave on the m_ side with
// m_tuser low; one status word with m_tuser high closes every file, and
// m_tlast marks the last word caused by one input byte.
// Throughput: one byte per cycle while the sink keeps m_tready high, except that
// a byte yielding two words (a sample pair and the status) holds s_tready low until
// the first of them is taken. A byte yields zero, one or two words; they appear in
// the cycle after the byte is taken.
// Each byte is parsed combinationally by the phase controller and datapath;
// the rate is set by the two-word result buffer, which must be empty, or
// down to its last word that is being taken, before the next byte is accepted.
// When the sink stalls, s_tready drops until the buffer drains; nothing is lost.
// Reset clears the parser, loads the register defaults (rate 48000, max frames
// 28800000, max file bytes 536870912) and empties the buffer. After the last
// byte of a file the parser starts clean on the next file. Registers are written
// through cfg_we/cfg_index/cfg_data by the user while idle; the block does not check.
`include "wav_stream_parser_macros.svh"
module wav_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	input  logic        s_tlast,   // end_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // left_sample[31:0], right_sample[63:32], status_code[67:64]
	output logic        m_tuser,   // result_kind
	output logic        m_tlast,   // final_result
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	wsp_pkg::cmd_t  cmd;
	wsp_pkg::stat_t stat;
	wsp_pkg::res_t  head;
	logic           acc, sample_valid, status_valid;
	logic [31:0]    left, right;
	logic [3:0]     status_code;
	logic [1:0]     count;

	assign acc = s_tvalid && s_tready;

	wsp_ctrl u_ctrl (
		.clk, .arst_n, .acc, .eof(s_tlast), .stat, .cmd, .status_valid, .status_code
	);

	wsp_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .acc, .in_byte(s_tdata),
		.cmd, .stat, .sample_valid, .left, .right
	);

	wsp_outq u_outq (
		.clk, .arst_n, .push(acc), .sample_valid, .left, .right, .status_valid,
		.status_code, .ready(s_tready), .m_tvalid, .m_tready, .head, .count
	);

	// output word packing
	assign m_tdata = {4'd0, head.code, head.right, head.left};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

	`WSP_ASSERT_NEXT(a_eof_gives_word, clk, arst_n, acc && s_tlast, m_tvalid, "no status after last byte")
	`WSP_ASSERT_NOW(a_full_blocks, clk, arst_n, count == 2'd2, !s_tready, "byte taken with full buffer")
	`WSP_ASSERT_NOW(a_status_last, clk, arst_n, m_tvalid && m_tuser, m_tlast, "status word not last")

endmodule
